### rtl/core/npgw_pkg.sv
`timescale 1ns / 1ps

package npgw_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_NEIGHBOURS = 6;

  // Fixed field and datapath widths.
  localparam int COORD_BITS = 16;
  localparam int SLOT_W     = 10;
  localparam int CFG_W      = 11;
  localparam int IDX_OUT_W  = 10;
  localparam int W_W        = 17;
  localparam int DIST_W     = 2 * COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int THM_W      = DIST_W + 6;
  localparam int DVD_W      = 40;
  localparam int DVS_W      = 32;
  localparam int ROOT_W     = DVD_W / 2;
  localparam int PROD_W     = 2 * W_W;

  // Arithmetic constants.
  localparam logic [COORD_BITS-1:0] RADIUS_MIN  = COORD_BITS'((64'd1 << COORD_BITS) / 1000);
  localparam logic [THM_W-1:0]      GAP_NUM     = THM_W'(49);
  localparam logic [DVS_W-1:0]      GAP_DEN     = DVS_W'(100);
  localparam logic [DVD_W-1:0]      EXP_LIMIT   = DVD_W'(192);
  localparam logic [PROD_W-1:0]     ROUND_HALF  = PROD_W'(32768);
  localparam logic [W_W-1:0]        WEIGHT_ONE  = W_W'(65536);

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_THIRD,
    DIV_EXP,
    DIV_NORM
  } div_sel_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_SIG2,
    ST_GAP,
    ST_THIRD_DIV,
    ST_THIRD_WAIT,
    ST_SQRT_WAIT,
    ST_SIG2_GROWN,
    ST_A_DIV,
    ST_A_WAIT,
    ST_RAW,
    ST_NORM,
    ST_NORM_WAIT
  } npgw_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_wr;
    logic     query_start;
    logic     scan_issue;
    logic     sig2_calc;
    logic     gap_mult;
    logic     div_start;
    div_sel_e div_sel;
    logic     sqrt_start;
    logic     sig_update;
    logic     exp_mult;
    logic     raw_store;
    logic     k_clear;
    logic     emit_none;
    logic     emit_direct;
    logic     emit_div;
  } npgw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic issue_done;
    logic pipe_busy;
    logic count_zero;
    logic gap_hit;
    logic div_done;
    logic sqrt_done;
    logic k_last;
    logic sum_zero;
  } npgw_stat_t;

  // exp(-n) for integer n, Q1.16.
  function automatic logic [W_W-1:0] exp_int(input logic [3:0] n);
    logic [W_W-1:0] v;
    case (n)
      4'd0:    v = W_W'(65536);
      4'd1:    v = W_W'(24109);
      4'd2:    v = W_W'(8869);
      4'd3:    v = W_W'(3263);
      4'd4:    v = W_W'(1200);
      4'd5:    v = W_W'(442);
      4'd6:    v = W_W'(162);
      4'd7:    v = W_W'(60);
      4'd8:    v = W_W'(22);
      4'd9:    v = W_W'(8);
      4'd10:   v = W_W'(3);
      4'd11:   v = W_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // exp(-f/16) for the fractional sixteenths, Q1.16.
  function automatic logic [W_W-1:0] exp_frac(input logic [3:0] f);
    logic [W_W-1:0] v;
    case (f)
      4'd0:    v = W_W'(65536);
      4'd1:    v = W_W'(61565);
      4'd2:    v = W_W'(57835);
      4'd3:    v = W_W'(54331);
      4'd4:    v = W_W'(51039);
      4'd5:    v = W_W'(47947);
      4'd6:    v = W_W'(45042);
      4'd7:    v = W_W'(42313);
      4'd8:    v = W_W'(39750);
      4'd9:    v = W_W'(37341);
      4'd10:   v = W_W'(35079);
      4'd11:   v = W_W'(32954);
      4'd12:   v = W_W'(30957);
      4'd13:   v = W_W'(29081);
      4'd14:   v = W_W'(27319);
      4'd15:   v = W_W'(25665);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/npgw_div.sv
`timescale 1ns / 1ps

module npgw_div
  import npgw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int SCW = $clog2(DVD_W + 1);

  logic             active_q;
  logic             done_q;
  logic [SCW-1:0]   cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (active_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == SCW'(DVD_W - 1)) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (active_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/core/npgw_sqrt.sv
`timescale 1ns / 1ps

module npgw_sqrt
  import npgw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  value_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int SCW = $clog2(ROOT_W + 1);

  logic             active_q;
  logic             done_q;
  logic [SCW-1:0]   cnt_q;
  logic [DVD_W-1:0] val_q;
  logic [DVD_W-1:0] root_q;
  logic [DVD_W-1:0] bit_q;
  logic [DVD_W-1:0] trial;
  logic             fits;

  assign trial = root_q + bit_q;
  assign fits  = (val_q >= trial);

  // Iteration counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (active_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == SCW'(ROOT_W - 1)) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Digit-by-digit floor square root, one result bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      root_q <= '0;
      bit_q  <= DVD_W'(1) << (DVD_W - 2);
    end else if (active_q) begin
      if (fits) begin
        val_q  <= val_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[ROOT_W-1:0];

endmodule

### rtl/core/npgw_ctrl.sv
`timescale 1ns / 1ps

module npgw_ctrl
  import npgw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       action_i,
  input  npgw_stat_t stat_i,
  output npgw_cmd_t  cmd_o,
  output logic       busy_o
);

  npgw_state_e state_q;
  npgw_state_e state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (action_i) begin
            cmd_o.query_start = 1'b1;
            state_d = ST_SCAN;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = !stat_i.issue_done;
        if (stat_i.issue_done && !stat_i.pipe_busy) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.count_zero) begin
          cmd_o.emit_none = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SIG2;
        end
      end
      ST_SIG2: begin
        cmd_o.sig2_calc = 1'b1;
        state_d = ST_GAP;
      end
      ST_GAP: begin
        if (stat_i.gap_hit) begin
          cmd_o.gap_mult = 1'b1;
          state_d = ST_THIRD_DIV;
        end else begin
          state_d = ST_A_DIV;
        end
      end
      ST_THIRD_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_THIRD;
        state_d = ST_THIRD_WAIT;
      end
      ST_THIRD_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d = ST_SQRT_WAIT;
        end
      end
      ST_SQRT_WAIT: begin
        if (stat_i.sqrt_done) begin
          cmd_o.sig_update = 1'b1;
          state_d = ST_SIG2_GROWN;
        end
      end
      ST_SIG2_GROWN: begin
        cmd_o.sig2_calc = 1'b1;
        state_d = ST_A_DIV;
      end
      ST_A_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_EXP;
        state_d = ST_A_WAIT;
      end
      ST_A_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.exp_mult = 1'b1;
          state_d = ST_RAW;
        end
      end
      ST_RAW: begin
        cmd_o.raw_store = 1'b1;
        if (stat_i.k_last) begin
          cmd_o.k_clear = 1'b1;
          state_d = ST_NORM;
        end else begin
          state_d = ST_A_DIV;
        end
      end
      ST_NORM: begin
        if (stat_i.sum_zero) begin
          cmd_o.emit_direct = 1'b1;
          if (stat_i.k_last) begin
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_NORM;
          state_d = ST_NORM_WAIT;
        end
      end
      ST_NORM_WAIT: begin
        cmd_o.div_sel = DIV_NORM;
        if (stat_i.div_done) begin
          cmd_o.emit_div = 1'b1;
          state_d = stat_i.k_last ? ST_IDLE : ST_NORM;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### rtl/core/npgw_dp.sv
`timescale 1ns / 1ps

module npgw_dp
  import npgw_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int NEIGHBOURS = DEF_NEIGHBOURS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  npgw_cmd_t             cmd_i,
  output npgw_stat_t            stat_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic [SLOT_W-1:0]     point_slot_i,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  input  logic [COORD_BITS-1:0] radius_i,
  output logic                  result_valid_o,
  output logic [IDX_OUT_W-1:0]  neighbour_index_o,
  output logic [W_W-1:0]        weight_o,
  output logic                  found_o,
  output logic                  last_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = $clog2(NEIGHBOURS);
  localparam int NW = $clog2(NEIGHBOURS + 1);
  localparam int SW = W_W + NW;

  // Point table.
  logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic [COORD_BITS-1:0] mem_y [MAX_POINTS];
  logic [COORD_BITS-1:0] rd_x_q, rd_y_q;

  logic [CW-1:0]         pts_q;
  logic [CW-1:0]         idx_q;
  logic [COORD_BITS-1:0] cx_q, cy_q, sig_q;
  logic [SQ_W-1:0]       sig2_q;

  logic                  v1_q, v2_q;
  logic [AW-1:0]         i1_q, i2_q;
  logic [SQ_W-1:0]       sqx_q, sqy_q;
  logic [COORD_BITS-1:0] dx, dy;
  logic [DIST_W-1:0]     d_new;

  logic [DIST_W-1:0]     dist_q [NEIGHBOURS];
  logic [AW-1:0]         bidx_q [NEIGHBOURS];
  logic [DIST_W-1:0]     dist_d [NEIGHBOURS];
  logic [AW-1:0]         bidx_d [NEIGHBOURS];
  logic [NEIGHBOURS-1:0] cand;
  logic [NEIGHBOURS-1:0] move;
  logic [NW-1:0]         cnt_q;

  logic [THM_W-1:0]      thm_q;
  logic [DIST_W-1:0]     third;
  logic [NW-1:0]         k_q;
  logic [KW-1:0]         kk;
  logic [W_W-1:0]        raw_q [NEIGHBOURS];
  logic [W_W-1:0]        raw_v;
  logic [SW-1:0]         sum_q;
  logic [PROD_W-1:0]     prod_q;
  logic [PROD_W-1:0]     prod_rnd;
  logic                  zero_q;

  logic [DVD_W-1:0]      dvd;
  logic [DVS_W-1:0]      dvs;
  logic [DVD_W-1:0]      quot;
  logic                  div_done;
  logic [ROOT_W-1:0]     root;
  logic                  sqrt_done;
  logic                  slot_ok;

  logic                  res_valid_q;
  logic [IDX_OUT_W-1:0]  res_idx_q;
  logic [W_W-1:0]        res_w_q;
  logic                  res_found_q;
  logic                  res_last_q;

  assign kk      = k_q[KW-1:0];
  assign slot_ok = (32'(point_slot_i) < 32'(MAX_POINTS));

  // Points-in-use register, saturated to the table size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q <= '0;
    end else if (cfg_valid_i) begin
      pts_q <= (32'(cfg_data_i) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(cfg_data_i);
    end
  end

  // Table write on a load and registered read during the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && slot_ok) begin
      mem_x[AW'(point_slot_i)] <= coord_x_i;
      mem_y[AW'(point_slot_i)] <= coord_y_i;
    end
    if (cmd_i.scan_issue) begin
      rd_x_q <= mem_x[idx_q[AW-1:0]];
      rd_y_q <= mem_y[idx_q[AW-1:0]];
    end
  end

  // Query operands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      cx_q  <= coord_x_i;
      cy_q  <= coord_y_i;
      sig_q <= (radius_i < RADIUS_MIN) ? RADIUS_MIN : radius_i;
    end else if (cmd_i.sig_update && (root > ROOT_W'(sig_q))) begin
      sig_q <= root[COORD_BITS-1:0];
    end
    if (cmd_i.sig2_calc) begin
      sig2_q <= sig_q * sig_q;
    end
    if (cmd_i.gap_mult) begin
      thm_q <= THM_W'(third) * GAP_NUM;
    end
  end

  // Scan pipeline control: address, read, square.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (cmd_i.query_start) begin
        idx_q <= '0;
      end else if (cmd_i.scan_issue) begin
        idx_q <= idx_q + 1'b1;
      end
      v1_q <= cmd_i.scan_issue;
      v2_q <= v1_q;
    end
  end

  assign dx = (rd_x_q > cx_q) ? (rd_x_q - cx_q) : (cx_q - rd_x_q);
  assign dy = (rd_y_q > cy_q) ? (rd_y_q - cy_q) : (cy_q - rd_y_q);

  always_ff @(posedge clk_i) begin
    i1_q  <= idx_q[AW-1:0];
    i2_q  <= i1_q;
    sqx_q <= dx * dx;
    sqy_q <= dy * dy;
  end

  assign d_new = DIST_W'(sqx_q) + DIST_W'(sqy_q);

  // Sorted insertion: a slot moves if it is empty or farther than the new point.
  always_comb begin
    for (int k = 0; k < NEIGHBOURS; k++) begin
      cand[k] = (NW'(k) >= cnt_q) || (dist_q[k] > d_new);
    end
    move = {cand[NEIGHBOURS-2:0], 1'b0};
    for (int k = 0; k < NEIGHBOURS; k++) begin
      dist_d[k] = dist_q[k];
      bidx_d[k] = bidx_q[k];
      if (move[k]) begin
        dist_d[k] = dist_q[k-1];
        bidx_d[k] = bidx_q[k-1];
      end else if (cand[k]) begin
        dist_d[k] = d_new;
        bidx_d[k] = i2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      for (int k = 0; k < NEIGHBOURS; k++) begin
        dist_q[k] <= dist_d[k];
        bidx_q[k] <= bidx_d[k];
      end
    end
  end

  // Neighbour count, weight index and weight sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      k_q   <= '0;
      sum_q <= '0;
    end else if (cmd_i.query_start) begin
      cnt_q <= '0;
      k_q   <= '0;
      sum_q <= '0;
    end else begin
      if (v2_q && (cnt_q < NW'(NEIGHBOURS))) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.raw_store) begin
        sum_q <= sum_q + SW'(raw_v);
      end
      if (cmd_i.k_clear) begin
        k_q <= '0;
      end else if (cmd_i.raw_store || cmd_i.emit_direct || cmd_i.emit_div) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  assign third = (cnt_q >= NW'(3)) ? dist_q[2] : dist_q[0];

  // Exponent lookup: integer and fractional parts multiplied, then rounded.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_mult) begin
      zero_q <= (quot >= EXP_LIMIT);
      prod_q <= exp_int(quot[7:4]) * exp_frac(quot[3:0]);
    end
    if (cmd_i.raw_store) begin
      raw_q[kk] <= raw_v;
    end
  end

  assign prod_rnd = prod_q + ROUND_HALF;
  assign raw_v    = zero_q ? '0 : prod_rnd[W_W+15:16];

  // Shared divider operands.
  always_comb begin
    case (cmd_i.div_sel)
      DIV_THIRD: begin
        dvd = DVD_W'(thm_q);
        dvs = GAP_DEN;
      end
      DIV_EXP: begin
        dvd = DVD_W'(dist_q[kk]) << 3;
        dvs = sig2_q;
      end
      DIV_NORM: begin
        dvd = (DVD_W'(raw_q[kk]) << 16) + DVD_W'(sum_q >> 1);
        dvs = DVS_W'(sum_q);
      end
      default: begin
        dvd = '0;
        dvs = '1;
      end
    endcase
  end

  npgw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  npgw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (quot),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // Result register: shown for one cycle per emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_none || cmd_i.emit_direct || cmd_i.emit_div;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_none) begin
      res_idx_q   <= '0;
      res_w_q     <= '0;
      res_found_q <= 1'b0;
      res_last_q  <= 1'b1;
    end else if (cmd_i.emit_direct || cmd_i.emit_div) begin
      res_idx_q   <= IDX_OUT_W'(bidx_q[kk]);
      res_found_q <= 1'b1;
      res_last_q  <= stat_o.k_last;
      if (cmd_i.emit_div) begin
        res_w_q <= quot[W_W-1:0];
      end else begin
        res_w_q <= (k_q == '0) ? WEIGHT_ONE : '0;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    stat_o.issue_done = (idx_q >= pts_q);
    stat_o.pipe_busy  = v1_q || v2_q;
    stat_o.count_zero = (cnt_q == '0);
    stat_o.gap_hit    = (dist_q[0] > DIST_W'(sig2_q));
    stat_o.div_done   = div_done;
    stat_o.sqrt_done  = sqrt_done;
    stat_o.k_last     = ((k_q + 1'b1) == cnt_q);
    stat_o.sum_zero   = (sum_q == '0);
  end

  assign result_valid_o    = res_valid_q;
  assign neighbour_index_o = res_idx_q;
  assign weight_o          = res_w_q;
  assign found_o           = res_found_q;
  assign last_o            = res_last_q;

endmodule

### rtl/core/nearest_points_gaussian_weights.sv
`timescale 1ns / 1ps

// Nearest points with Gaussian weights. A load (action 0) writes one point
// into the table and keeps busy low. A query (action 1) holds busy high
// while it scans points_in_use table entries, one per cycle through a
// registered read and a squaring stage, then works out the weights with one
// shared bit-serial divider and a bit-serial square root, the root used
// only when the nearest point lies outside the radius; the final result
// appears in the same cycle as busy falls.
// Results come out one per strobe on result_valid_o, nearest first, and
// cannot be held off by the receiver: each is on the ports for exactly one
// cycle. Write points_in_use only while busy is low, and read no table
// entry that was never loaded.
module nearest_points_gaussian_weights
  import npgw_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int NEIGHBOURS = DEF_NEIGHBOURS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action_i,
  input  logic [SLOT_W-1:0]     point_slot_i,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  input  logic [COORD_BITS-1:0] radius_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i,
  output logic                  result_valid_o,
  output logic [IDX_OUT_W-1:0]  neighbour_index_o,
  output logic [W_W-1:0]        weight_o,
  output logic                  found_o,
  output logic                  last_o
);

  npgw_cmd_t  cmd;
  npgw_stat_t stat;
  logic       start_ok;

  // An item is taken only while no query is running.
  assign start_ok    = start && !busy;
  assign cfg_ready_o = 1'b1;

  npgw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_ok),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  npgw_dp #(
    .MAX_POINTS (MAX_POINTS),
    .NEIGHBOURS (NEIGHBOURS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .point_slot_i      (point_slot_i),
    .coord_x_i         (coord_x_i),
    .coord_y_i         (coord_y_i),
    .radius_i          (radius_i),
    .result_valid_o    (result_valid_o),
    .neighbour_index_o (neighbour_index_o),
    .weight_o          (weight_o),
    .found_o           (found_o),
    .last_o            (last_o)
  );

endmodule
